FILE: hdl/ipid_pkg.sv
// shared constants, register codes and types of the incremental pid unit
package ipid_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int DUTY_BITS          = 16;
    localparam int CFG_IDX_BITS       = 4;

    localparam int SETPOINT_RST = 30553;
    localparam int GAIN_P_RST   = 4110418;
    localparam int GAIN_I_RST   = 38923;
    localparam int GAIN_D_RST   = 0;

    localparam logic [DUTY_BITS-1:0] STEP_LIMIT_RST = 16'd393;
    localparam logic [DUTY_BITS-1:0] DUTY_FLOOR_RST = 16'd19661;
    localparam logic [DUTY_BITS-1:0] DUTY_CEIL_RST  = 16'd58982;
    localparam logic [DUTY_BITS-1:0] DUTY_START_RST = 16'd44237;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SETPOINT     = 4'd0,
        CFG_GAIN_P       = 4'd1,
        CFG_GAIN_I       = 4'd2,
        CFG_GAIN_D       = 4'd3,
        CFG_STEP_LIMIT   = 4'd4,
        CFG_DUTY_FLOOR   = 4'd5,
        CFG_DUTY_CEILING = 4'd6,
        CFG_DUTY_START   = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DUTY_BITS-1:0] step_limit;
        logic [DUTY_BITS-1:0] duty_floor;
        logic [DUTY_BITS-1:0] duty_ceiling;
    } t_duty_cfg;

    typedef struct packed {
        logic                 load;
        logic [DUTY_BITS-1:0] value;
    } t_duty_load;

endpackage

FILE: hdl/ipid_sample_if.sv
// stream interface carrying one feedback sample per transaction
interface ipid_sample_if import ipid_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: hdl/ipid_duty_if.sv
// stream interface carrying one duty result per transaction
interface ipid_duty_if import ipid_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty;
    logic                 applied;

    modport source (output valid, output duty, output applied, input ready);
    modport sink   (input valid, input duty, input applied, output ready);
endinterface

FILE: hdl/inverter_incremental_pid_unit.sv
// top level of the incremental pid duty controller
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------
//  i_in      | in  | valid / ready | sample
//  o_out     | out | valid / ready | duty, applied
//  i_cfg_*   | in  | write enable  | register index, write data
//
//  one transaction per cycle sustained while o_out is ready; a result passes through the stages below in order
//  three register stages: input, products of the three gain multipliers, result
//  synchronous reset empties the pipeline and loads the start duty
//  a stalled result holds; ready drops only when every stage is full
module inverter_incremental_pid_unit import ipid_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int CFG_W0        = (GAIN_FRAC_BITS > SAMPLE_BITS) ? GAIN_FRAC_BITS : SAMPLE_BITS,
    localparam int CFG_DATA_BITS = (CFG_W0 > DUTY_BITS) ? CFG_W0 : DUTY_BITS,
    localparam int PROD_BITS     = GAIN_FRAC_BITS + SAMPLE_BITS + 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    ipid_sample_if.sink              i_in,
    ipid_duty_if.source              o_out
);

    logic [SAMPLE_BITS-1:0]      w_setpoint;
    logic [GAIN_FRAC_BITS-1:0]   w_gain_p;
    logic [GAIN_FRAC_BITS-1:0]   w_gain_i;
    logic [GAIN_FRAC_BITS-1:0]   w_gain_d;
    t_duty_cfg                   w_duty_cfg;
    t_duty_load                  w_duty_load;
    logic                        w_prod_valid;
    logic                        w_back_ready;
    logic signed [PROD_BITS-1:0] w_prod_p;
    logic signed [PROD_BITS-1:0] w_prod_i;
    logic signed [PROD_BITS-1:0] w_prod_d;

    ipid_cfg #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .CFG_DATA_BITS  (CFG_DATA_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_setpoint  (w_setpoint),
        .o_gain_p    (w_gain_p),
        .o_gain_i    (w_gain_i),
        .o_gain_d    (w_gain_d),
        .o_duty_cfg  (w_duty_cfg),
        .o_duty_load (w_duty_load)
    );

    ipid_front #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_setpoint   (w_setpoint),
        .i_gain_p     (w_gain_p),
        .i_gain_i     (w_gain_i),
        .i_gain_d     (w_gain_d),
        .i_down_ready (w_back_ready),
        .o_valid      (w_prod_valid),
        .o_prod_p     (w_prod_p),
        .o_prod_i     (w_prod_i),
        .o_prod_d     (w_prod_d)
    );

    ipid_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_prod_valid),
        .o_ready     (w_back_ready),
        .i_prod_p    (w_prod_p),
        .i_prod_i    (w_prod_i),
        .i_prod_d    (w_prod_d),
        .i_duty_cfg  (w_duty_cfg),
        .i_duty_load (w_duty_load),
        .o_out       (o_out)
    );

endmodule

FILE: hdl/ipid_cfg.sv
// configuration register file of the incremental pid unit
module ipid_cfg import ipid_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int CFG_DATA_BITS  = GAIN_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic [SAMPLE_BITS-1:0]    o_setpoint,
    output logic [GAIN_FRAC_BITS-1:0] o_gain_p,
    output logic [GAIN_FRAC_BITS-1:0] o_gain_i,
    output logic [GAIN_FRAC_BITS-1:0] o_gain_d,
    output t_duty_cfg                 o_duty_cfg,
    output t_duty_load                o_duty_load
);

    logic [SAMPLE_BITS-1:0]    r_setpoint;
    logic [GAIN_FRAC_BITS-1:0] r_gain_p;
    logic [GAIN_FRAC_BITS-1:0] r_gain_i;
    logic [GAIN_FRAC_BITS-1:0] r_gain_d;
    t_duty_cfg                 r_duty_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint              <= SAMPLE_BITS'(SETPOINT_RST);
            r_gain_p                <= GAIN_FRAC_BITS'(GAIN_P_RST);
            r_gain_i                <= GAIN_FRAC_BITS'(GAIN_I_RST);
            r_gain_d                <= GAIN_FRAC_BITS'(GAIN_D_RST);
            r_duty_cfg.step_limit   <= STEP_LIMIT_RST;
            r_duty_cfg.duty_floor   <= DUTY_FLOOR_RST;
            r_duty_cfg.duty_ceiling <= DUTY_CEIL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETPOINT:     r_setpoint              <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_GAIN_P:       r_gain_p                <= i_cfg_data[GAIN_FRAC_BITS-1:0];
                CFG_GAIN_I:       r_gain_i                <= i_cfg_data[GAIN_FRAC_BITS-1:0];
                CFG_GAIN_D:       r_gain_d                <= i_cfg_data[GAIN_FRAC_BITS-1:0];
                CFG_STEP_LIMIT:   r_duty_cfg.step_limit   <= i_cfg_data[DUTY_BITS-1:0];
                CFG_DUTY_FLOOR:   r_duty_cfg.duty_floor   <= i_cfg_data[DUTY_BITS-1:0];
                CFG_DUTY_CEILING: r_duty_cfg.duty_ceiling <= i_cfg_data[DUTY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // the start value itself only matters as a load into the duty state
    assign o_duty_load.load  = i_cfg_we && (i_cfg_idx == CFG_DUTY_START);
    assign o_duty_load.value = i_cfg_data[DUTY_BITS-1:0];

    assign o_setpoint = r_setpoint;
    assign o_gain_p   = r_gain_p;
    assign o_gain_i   = r_gain_i;
    assign o_gain_d   = r_gain_d;
    assign o_duty_cfg = r_duty_cfg;

endmodule

FILE: hdl/ipid_front.sv
// input register, error history and product register of the pid pipeline
module ipid_front import ipid_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int PROD_BITS     = GAIN_FRAC_BITS + SAMPLE_BITS + 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ipid_sample_if.sink                 i_in,
    input  logic [SAMPLE_BITS-1:0]      i_setpoint,
    input  logic [GAIN_FRAC_BITS-1:0]   i_gain_p,
    input  logic [GAIN_FRAC_BITS-1:0]   i_gain_i,
    input  logic [GAIN_FRAC_BITS-1:0]   i_gain_d,
    input  logic                        i_down_ready,
    output logic                        o_valid,
    output logic signed [PROD_BITS-1:0] o_prod_p,
    output logic signed [PROD_BITS-1:0] o_prod_i,
    output logic signed [PROD_BITS-1:0] o_prod_d
);

    logic                        r_in_valid;
    logic [SAMPLE_BITS-1:0]      r_sample;
    logic signed [SAMPLE_BITS:0] r_e1;
    logic signed [SAMPLE_BITS:0] r_e2;
    logic                        r_prod_valid;
    logic signed [PROD_BITS-1:0] r_prod_p;
    logic signed [PROD_BITS-1:0] r_prod_i;
    logic signed [PROD_BITS-1:0] r_prod_d;

    logic                          w_en_in;
    logic                          w_en_prod;
    logic signed [SAMPLE_BITS:0]   w_e;
    logic signed [SAMPLE_BITS+1:0] w_dp;
    logic signed [SAMPLE_BITS+2:0] w_dd;
    logic signed [GAIN_FRAC_BITS:0] w_gp;
    logic signed [GAIN_FRAC_BITS:0] w_gi;
    logic signed [GAIN_FRAC_BITS:0] w_gd;

    assign w_en_prod  = !r_prod_valid || i_down_ready;
    assign w_en_in    = !r_in_valid || w_en_prod;
    assign i_in.ready = w_en_in;

    assign w_e  = $signed({1'b0, i_setpoint}) - $signed({1'b0, r_sample});
    assign w_dp = (SAMPLE_BITS+2)'(w_e) - (SAMPLE_BITS+2)'(r_e1);
    assign w_dd = (SAMPLE_BITS+3)'(w_e) - ((SAMPLE_BITS+3)'(r_e1) <<< 1)
                + (SAMPLE_BITS+3)'(r_e2);

    assign w_gp = $signed({1'b0, i_gain_p});
    assign w_gi = $signed({1'b0, i_gain_i});
    assign w_gd = $signed({1'b0, i_gain_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_e1         <= '0;
            r_e2         <= '0;
        end else begin
            if (w_en_in) begin
                r_in_valid <= i_in.valid;
            end
            if (w_en_prod) begin
                r_prod_valid <= r_in_valid;
                // history moves once per transaction, whether applied or not
                if (r_in_valid) begin
                    r_e2 <= r_e1;
                    r_e1 <= w_e;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_in && i_in.valid) begin
            r_sample <= i_in.sample;
        end
        if (w_en_prod && r_in_valid) begin
            r_prod_p <= PROD_BITS'(w_gp) * PROD_BITS'(w_dp);
            r_prod_i <= PROD_BITS'(w_gi) * PROD_BITS'(w_e);
            r_prod_d <= PROD_BITS'(w_gd) * PROD_BITS'(w_dd);
        end
    end

    assign o_valid  = r_prod_valid;
    assign o_prod_p = r_prod_p;
    assign o_prod_i = r_prod_i;
    assign o_prod_d = r_prod_d;

endmodule

FILE: hdl/ipid_back.sv
// increment sum, window test, step clamp, duty state and result register
module ipid_back import ipid_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int PROD_BITS     = GAIN_FRAC_BITS + SAMPLE_BITS + 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [PROD_BITS-1:0] i_prod_p,
    input  logic signed [PROD_BITS-1:0] i_prod_i,
    input  logic signed [PROD_BITS-1:0] i_prod_d,
    input  t_duty_cfg                   i_duty_cfg,
    input  t_duty_load                  i_duty_load,
    ipid_duty_if.source                 o_out
);

    localparam int ACC_BITS = PROD_BITS + 2;
    localparam int INC_BITS = (SAMPLE_BITS + 7 > DUTY_BITS + 2) ? SAMPLE_BITS + 7 : DUTY_BITS + 2;
    localparam int INC_SHIFT = GAIN_FRAC_BITS - 1;

    logic [DUTY_BITS-1:0] r_duty;
    logic                 r_out_valid;
    logic [DUTY_BITS-1:0] r_out_duty;
    logic                 r_out_applied;

    logic                         w_en_out;
    logic signed [ACC_BITS-1:0]   w_acc;
    logic signed [INC_BITS-1:0]   w_inc;
    logic signed [INC_BITS-1:0]   w_lim;
    logic signed [INC_BITS-1:0]   w_clip;
    logic signed [DUTY_BITS+1:0]  w_sum;
    logic [DUTY_BITS-1:0]         w_sat;
    logic                         w_inside;
    logic                         w_below;
    logic                         w_above;
    logic                         w_pos;
    logic                         w_neg;
    logic                         w_apply;
    logic [DUTY_BITS-1:0]         n_duty;

    assign w_en_out = !r_out_valid || o_out.ready;
    assign o_ready  = w_en_out;

    assign w_acc = ACC_BITS'(i_prod_p) + ACC_BITS'(i_prod_i) + ACC_BITS'(i_prod_d);
    assign w_inc = INC_BITS'(w_acc >>> INC_SHIFT);
    assign w_lim = $signed(INC_BITS'(i_duty_cfg.step_limit));

    assign w_below  = r_duty < i_duty_cfg.duty_floor;
    assign w_above  = r_duty > i_duty_cfg.duty_ceiling;
    assign w_inside = !w_below && !w_above;
    assign w_neg    = w_inc[INC_BITS-1];
    assign w_pos    = !w_neg && (w_inc != '0);
    assign w_apply  = w_inside || (w_below && w_pos) || (w_above && w_neg);

    always_comb begin
        if (w_inc >= w_lim) begin
            w_clip = w_lim;
        end else if (w_inc <= -w_lim) begin
            w_clip = -w_lim;
        end else begin
            w_clip = w_inc;
        end
    end

    assign w_sum = $signed({2'b00, r_duty}) + (DUTY_BITS+2)'(w_clip);

    always_comb begin
        if (w_sum[DUTY_BITS+1]) begin
            w_sat = '0;
        end else if (w_sum[DUTY_BITS]) begin
            w_sat = '1;
        end else begin
            w_sat = w_sum[DUTY_BITS-1:0];
        end
    end

    assign n_duty = w_apply ? w_sat : r_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty      <= DUTY_START_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_duty_load.load) begin
                r_duty <= i_duty_load.value;
            end else if (w_en_out && i_valid) begin
                r_duty <= n_duty;
            end
            if (w_en_out) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && i_valid) begin
            r_out_duty    <= n_duty;
            r_out_applied <= w_apply;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.duty    = r_out_duty;
    assign o_out.applied = r_out_applied;

endmodule

FILE: hdl/ipid_chk.sv
// port-level checker of the incremental pid unit and its bind
module ipid_chk import ipid_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [DUTY_BITS-1:0] i_out_duty,
    input logic                 i_out_applied
);

    // a held result keeps its transaction alive
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_duty) && $stable(i_out_applied))
        else $error("result changed while stalled");

    // the pipeline never back-pressures while the sink drains
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled with sink ready");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty result register");

endmodule

bind inverter_incremental_pid_unit ipid_chk u_ipid_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_duty    (o_out.duty),
    .i_out_applied (o_out.applied)
);
